// ----- rtl/core/hkrd_pkg.sv -----
// ----------------------------------------------------------------------------
// hkrd_pkg
// Shared types and constants for the HID keyboard report differ.
// ----------------------------------------------------------------------------
package hkrd_pkg;

    localparam int unsigned KEY_W    = 8;
    localparam int unsigned MOD_BITS = 8;
    localparam logic [KEY_W-1:0] MOD_BASE = 8'hE0;

    // One key event as it leaves the block.
    typedef struct packed {
        logic [KEY_W-1:0] key_code;
        logic             key_up;
        logic             last_event;
    } hkrd_event_t;

endpackage

// ----- rtl/core/hkrd_lane.sv -----
// ----------------------------------------------------------------------------
// hkrd_lane
// One compare lane: flags a non-empty key code that no slot of the other
// report holds.
// ----------------------------------------------------------------------------
module hkrd_lane
    import hkrd_pkg::*;
#(
    parameter int unsigned KEY_SLOTS = 6
)
(
    input  logic [KEY_W-1:0]                code,
    input  logic [KEY_SLOTS-1:0][KEY_W-1:0] other_keys,
    output logic                            hit
);

    logic [KEY_SLOTS-1:0] match;

    always_comb
    begin
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            match[i] = (other_keys[i] == code);
        end
        hit = (code != '0) && !(|match);
    end

endmodule

// ----- rtl/core/hkrd_serializer.sv -----
// ----------------------------------------------------------------------------
// hkrd_serializer
// Merges the lane flags into a pending event mask and sends one event per
// cycle while the output is not stalled, earliest first, through an output register.
// ----------------------------------------------------------------------------
module hkrd_serializer
    import hkrd_pkg::*;
#(
    parameter int unsigned EVENTS = 28
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic [EVENTS-1:0]            ev_mask,
    input  logic [EVENTS-1:0][KEY_W-1:0] ev_code,
    output logic                         load_ready,
    output logic                         out_valid,
    input  logic                         out_ready,
    output hkrd_event_t                  out_event
);

    localparam int unsigned HALF = EVENTS / 2;

    logic [EVENTS-1:0]            mask_reg;
    logic [EVENTS-1:0]            mask_next;
    logic [EVENTS-1:0][KEY_W-1:0] code_reg;
    logic                         valid_reg;
    logic                         valid_next;
    hkrd_event_t                  event_reg;
    hkrd_event_t                  event_next;

    logic [EVENTS-1:0] lowest;
    logic [EVENTS-1:0] remaining;
    logic [KEY_W-1:0]  sel_code;
    logic              pop;

    always_comb
    begin
        lowest    = mask_reg & (~mask_reg + 1'b1);
        remaining = mask_reg & ~lowest;
        sel_code  = '0;
        for (int i = 0; i < EVENTS; i++)
        begin
            sel_code = sel_code | (code_reg[i] & {KEY_W{lowest[i]}});
        end
        pop        = (|mask_reg) && (!valid_reg || out_ready);
        load_ready = !(|mask_reg) || (pop && !(|remaining));

        mask_next  = mask_reg;
        valid_next = valid_reg;
        event_next = event_reg;
        if (pop)
        begin
            mask_next             = remaining;
            valid_next            = 1'b1;
            event_next.key_code   = sel_code;
            event_next.key_up     = |lowest[EVENTS-1:HALF];
            event_next.last_event = !(|remaining);
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            mask_next = ev_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg  <= mask_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        event_reg <= event_next;
        if (load)
        begin
            code_reg <= ev_code;
        end
    end

    assign out_valid = valid_reg;
    assign out_event = event_reg;

endmodule

// ----- rtl/core/hid_keyboard_report_differ.sv -----
// ----------------------------------------------------------------------------
// hid_keyboard_report_differ
// Compares each boot keyboard report with the previous one and streams
// press and release events.
// ----------------------------------------------------------------------------
// The events of an accepted report are stored in a pending mask and sent
// from there through an output register. Throughput: one event per cycle
// while the sink does not stall; a report that causes no events leaves the
// input ready, and the next report is taken in the cycle that the last
// event leaves the pending mask.
// Reset clears the stored report to all zero and empties the output.
// ----------------------------------------------------------------------------
module hid_keyboard_report_differ
    import hkrd_pkg::*;
#(
    parameter int unsigned KEY_SLOTS = 6
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0 up: modifiers, key_slot_0 .. key_slot_(KEY_SLOTS-1).
    input  logic [KEY_W*(KEY_SLOTS+1)-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Fields from bit 0 up: key_code.
    output logic [KEY_W-1:0]              m_tdata,
    // Fields from bit 0 up: key_up.
    output logic                          m_tuser,
    output logic                          m_tlast
);

    // Event slots in delivery order: modifier presses (bit 7 first), key
    // presses in slot order, then the same two groups for releases.
    localparam int unsigned HALF   = MOD_BITS + KEY_SLOTS;
    localparam int unsigned EVENTS = 2 * HALF;

    logic [MOD_BITS-1:0]            prev_mods_reg;
    logic [KEY_SLOTS-1:0][KEY_W-1:0] prev_keys_reg;

    logic [MOD_BITS-1:0]             new_mods;
    logic [KEY_SLOTS-1:0][KEY_W-1:0] new_keys;
    logic [KEY_SLOTS-1:0]            press_hit;
    logic [KEY_SLOTS-1:0]            release_hit;
    logic [EVENTS-1:0]               ev_mask;
    logic [EVENTS-1:0][KEY_W-1:0]    ev_code;
    logic                            accept;
    logic                            load_ready;
    hkrd_event_t                     out_event;

    assign new_mods = s_tdata[MOD_BITS-1:0];
    assign accept   = s_tvalid && load_ready;
    assign s_tready = load_ready;

    // Each key slot gets two lanes: its new code searched in the previous
    // report (press), and its previous code searched in the new one (release).
    for (genvar g = 0; g < KEY_SLOTS; g++)
    begin : g_lane
        assign new_keys[g] = s_tdata[KEY_W*(g+1) +: KEY_W];

        hkrd_lane #(.KEY_SLOTS(KEY_SLOTS)) u_press
        (
            .code       (new_keys[g]),
            .other_keys (prev_keys_reg),
            .hit        (press_hit[g])
        );

        hkrd_lane #(.KEY_SLOTS(KEY_SLOTS)) u_release
        (
            .code       (prev_keys_reg[g]),
            .other_keys (new_keys),
            .hit        (release_hit[g])
        );
    end

    // Modifier bits need no lane: a plain bitwise compare per bit.
    always_comb
    begin
        for (int i = 0; i < MOD_BITS; i++)
        begin
            ev_mask[i]        = new_mods[MOD_BITS-1-i] && !prev_mods_reg[MOD_BITS-1-i];
            ev_mask[HALF + i] = prev_mods_reg[MOD_BITS-1-i] && !new_mods[MOD_BITS-1-i];
            ev_code[i]        = MOD_BASE + KEY_W'(MOD_BITS - 1 - i);
            ev_code[HALF + i] = MOD_BASE + KEY_W'(MOD_BITS - 1 - i);
        end
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            ev_mask[MOD_BITS + i]        = press_hit[i];
            ev_mask[HALF + MOD_BITS + i] = release_hit[i];
            ev_code[MOD_BITS + i]        = new_keys[i];
            ev_code[HALF + MOD_BITS + i] = prev_keys_reg[i];
        end
    end

    // The stored report moves on as soon as a report is taken; its events
    // already sit in the serializer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_mods_reg <= '0;
            prev_keys_reg <= '0;
        end
        else if (accept)
        begin
            prev_mods_reg <= new_mods;
            prev_keys_reg <= new_keys;
        end
    end

    hkrd_serializer #(.EVENTS(EVENTS)) u_serializer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .ev_mask    (ev_mask),
        .ev_code    (ev_code),
        .load_ready (load_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_event  (out_event)
    );

    assign m_tdata = out_event.key_code;
    assign m_tuser = out_event.key_up;
    assign m_tlast = out_event.last_event;

endmodule

// ----- rtl/core/hkrd_checker.sv -----
// ----------------------------------------------------------------------------
// hkrd_checker
// Port-level checks for the HID keyboard report differ.
// ----------------------------------------------------------------------------
module hkrd_checker
    import hkrd_pkg::*;
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [KEY_W-1:0]               m_tdata,
    input logic                           m_tuser,
    input logic                           m_tlast
);

    // The output register comes out of reset empty.
    a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> !m_tvalid)
        else $error("output valid after reset");

    // A stalled event holds its contents.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("stalled event changed");

    // Empty slots never turn into events.
    a_no_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata != '0)
        else $error("event with zero key code");

    // Within one report, releases come after all presses.
    a_release_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser && !m_tlast |=> !m_tvalid || m_tuser)
        else $error("press after release in one report");

endmodule

bind hid_keyboard_report_differ hkrd_checker u_hkrd_checker (.*);

// ----- test/hkrd_event_checker.sv -----
// ----------------------------------------------------------------------------
// hkrd_event_checker
// Watches both streams of the keyboard report differ, predicts the key events
// of every accepted report and compares them with the events that come out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hkrd_event_checker
    import hkrd_pkg::*;
#(
    parameter int unsigned KEY_SLOTS = 6
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // Fields from bit 0 up: modifiers, key_slot_0 .. key_slot_(KEY_SLOTS-1).
    input  logic [KEY_W*(KEY_SLOTS+1)-1:0] s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0 up: key_code.
    input  logic [KEY_W-1:0]               m_tdata,
    // Fields from bit 0 up: key_up.
    input  logic                           m_tuser,
    input  logic                           m_tlast,
    output int                             mismatch_count,
    output int                             events_pending
);

    localparam int unsigned SHOWN_MISMATCHES = 10;

    typedef logic [KEY_SLOTS-1:0][KEY_W-1:0] key_slots_t;

    // Our own copy of the report held by the block.
    logic [MOD_BITS-1:0] held_mods;
    key_slots_t          held_keys;

    hkrd_event_t expected_events[$];
    hkrd_event_t report_events[$];

    function automatic bit slots_hold(input key_slots_t slots, input logic [KEY_W-1:0] code);
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            if (slots[i] == code)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Appends one event for every modifier or key present in report a and
    // missing from report b, modifiers from bit 7 down, keys in slot order.
    function automatic void collect_changes(input logic [MOD_BITS-1:0] a_mods,
                                            input key_slots_t          a_keys,
                                            input logic [MOD_BITS-1:0] b_mods,
                                            input key_slots_t          b_keys,
                                            input logic                released);
        hkrd_event_t ev;
        ev.key_up     = released;
        ev.last_event = 1'b0;
        for (int b = MOD_BITS - 1; b >= 0; b--)
        begin
            if (a_mods[b] && !b_mods[b])
            begin
                ev.key_code = MOD_BASE + KEY_W'(b);
                report_events.push_back(ev);
            end
        end
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            if (a_keys[i] != '0 && !slots_hold(b_keys, a_keys[i]))
            begin
                ev.key_code = a_keys[i];
                report_events.push_back(ev);
            end
        end
    endfunction

    function automatic void predict_key_events(input logic [MOD_BITS-1:0] mods,
                                               input key_slots_t          keys);
        hkrd_event_t closing;
        report_events.delete();
        collect_changes(mods, keys, held_mods, held_keys, 1'b0);
        collect_changes(held_mods, held_keys, mods, keys, 1'b1);
        if (report_events.size() > 0)
        begin
            closing = report_events[report_events.size() - 1];
            closing.last_event = 1'b1;
            report_events[report_events.size() - 1] = closing;
        end
        foreach (report_events[i])
            expected_events.push_back(report_events[i]);
        held_mods = mods;
        held_keys = keys;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        hkrd_event_t want;
        if (!rst_n)
        begin
            held_mods = '0;
            held_keys = '0;
            expected_events.delete();
            events_pending <= 0;
        end
        else
        begin
            // Check the outgoing event first; an event never stems from a
            // report accepted at the same edge.
            if (m_tvalid && m_tready)
            begin
                if (expected_events.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= SHOWN_MISMATCHES)
                        $display("%0t: unexpected event code %02h release %0b last %0b",
                                 $realtime, m_tdata, m_tuser, m_tlast);
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (want.key_code !== m_tdata || want.key_up !== m_tuser
                        || want.last_event !== m_tlast)
                    begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= SHOWN_MISMATCHES)
                            $display({"%0t: event differs: expected code %02h release %0b ",
                                      "last %0b, got code %02h release %0b last %0b"},
                                     $realtime, want.key_code, want.key_up,
                                     want.last_event, m_tdata, m_tuser, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_key_events(s_tdata[MOD_BITS-1:0],
                                   s_tdata[KEY_W*(KEY_SLOTS+1)-1:KEY_W]);
            events_pending <= expected_events.size();
        end
    end

endmodule

// ----- test/hid_keyboard_report_differ_tb.sv -----
// ----------------------------------------------------------------------------
// hid_keyboard_report_differ_tb
// Feeds boot keyboard reports into the report differ: a directed set of
// corner reports, then random typing sequences with noise, under bursty input
// and a stalling event sink. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hid_keyboard_report_differ_tb;
    import hkrd_pkg::*;

    localparam int unsigned KEY_SLOTS = 6;
    localparam int unsigned REPORT_W  = KEY_W * (KEY_SLOTS + 1);

    // Random reports after the directed part.
    localparam int RANDOM_REPORTS   = 380;
    // Length of the one long sink stall that backs the block up.
    localparam int LONG_HOLD_CYCLES = 300;
    // Cycles without any transfer on either side before the run is abandoned.
    // Well above the long stall plus a full 20 event report under heavy stall.
    localparam int IDLE_LIMIT       = 3000;
    // The block shows its first event once a report has passed its pending mask
    // and output register; spare cycles after that catch any event that should not be there.
    localparam int SETTLE_CYCLES    = 4;

    typedef logic [KEY_SLOTS-1:0][KEY_W-1:0] key_slots_t;

    // Behavior of the event sink over one stretch of cycles.
    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_RHYTHM
    } sink_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // Fields from bit 0 up: modifiers, key_slot_0 .. key_slot_5.
    logic [REPORT_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // Fields from bit 0 up: key_code.
    logic [KEY_W-1:0]      m_tdata;
    // Fields from bit 0 up: key_up.
    logic                  m_tuser;
    logic                  m_tlast;

    int mismatch_count;
    int events_pending;
    int idle_cycles;

    // Set by the stimulus, taken and cleared by the sink process.
    bit long_hold_req;

    // Report the stimulus is working on; random steps edit it in place so
    // that most reports look like a person typing.
    logic [MOD_BITS-1:0] cur_mods;
    key_slots_t          cur_keys;
    int                  burst_left;

    hid_keyboard_report_differ #(
        .KEY_SLOTS (KEY_SLOTS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    hkrd_event_checker #(
        .KEY_SLOTS (KEY_SLOTS)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .events_pending (events_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Watchdog: any transfer on either side counts as progress.
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Offers the current report and returns at the edge where it was taken.
    // The sender works in bursts; at the end of a burst, or when the caller
    // wants to pause afterwards, valid drops at that same edge so the report
    // is not taken twice.
    task automatic send_current(input bit stop_after);
        s_tvalid <= 1'b1;
        s_tdata  <= {cur_keys, cur_mods};
        do
            @(posedge clk);
        while (!s_tready);
        if (burst_left > 0 && !stop_after)
        begin
            burst_left = burst_left - 1;
        end
        else
        begin
            s_tvalid <= 1'b0;
            // A gap keeps valid from being lowered and
            // raised within the same step.
            if (!stop_after)
                repeat ($urandom_range(1, 12)) @(posedge clk);
            // One burst in four, at random, is long, which gives stretches with no gaps.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic send_report(input logic [KEY_W-1:0] mods,
                               input logic [KEY_W-1:0] k0, input logic [KEY_W-1:0] k1,
                               input logic [KEY_W-1:0] k2, input logic [KEY_W-1:0] k3,
                               input logic [KEY_W-1:0] k4, input logic [KEY_W-1:0] k5);
        cur_mods    = mods;
        cur_keys[0] = k0;
        cur_keys[1] = k1;
        cur_keys[2] = k2;
        cur_keys[3] = k3;
        cur_keys[4] = k4;
        cur_keys[5] = k5;
        send_current(1'b0);
    endtask

    // Waits until every predicted event has left the block, then lets it
    // settle. The pending count is registered in the checker, so the task lets
    // it update before looking at it.
    task automatic wait_events_drained();
        @(posedge clk);
        while (events_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One random step. Most steps edit the held report a little, the way
    // real typing does: a modifier goes down or up, a key lands in a slot or
    // leaves it. A small key pool makes repeated codes and keys that merely
    // move between slots common. The rest are unchanged reports, raw noise
    // over the full field range, rotated slots, and a full clear.
    task automatic step_random_report();
        int pick;
        int edits;
        int slot;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            edits = $urandom_range(1, 3);
            repeat (edits)
            begin
                slot = $urandom_range(0, KEY_SLOTS - 1);
                case ($urandom_range(0, 2))
                    0:       cur_mods = cur_mods ^ (8'h01 << $urandom_range(0, MOD_BITS - 1));
                    1:       cur_keys[slot] = KEY_W'($urandom_range(4, 15));
                    default: cur_keys[slot] = '0;
                endcase
            end
        end
        else if (pick < 80)
        begin
            // Repeat of the held report: no events expected.
        end
        else if (pick < 90)
        begin
            cur_mods = KEY_W'($urandom_range(0, 255));
            for (int i = 0; i < KEY_SLOTS; i++)
                cur_keys[i] = KEY_W'($urandom_range(0, 255));
        end
        else if (pick < 95)
        begin
            cur_keys = {cur_keys[KEY_SLOTS-2:0], cur_keys[KEY_SLOTS-1]};
        end
        else
        begin
            cur_mods = '0;
            cur_keys = '0;
        end
    endtask

    // Event sink: stretches of different stall patterns, plus one long hold
    // when the stimulus asks for it.
    initial
    begin : sink
        sink_mode_t mode;
        int         span;
        bit         ready_now;
        m_tready = 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                mode = sink_mode_t'($urandom_range(0, 3));
                span = $urandom_range(4, 40);
                for (int n = 0; n < span; n++)
                begin
                    case (mode)
                        SINK_OPEN:   ready_now = 1'b1;
                        SINK_COIN:   ready_now = $urandom_range(0, 1);
                        SINK_SPARSE: ready_now = ($urandom_range(0, 3) == 0);
                        default:     ready_now = (n % 3 != 2);
                    endcase
                    m_tready <= ready_now;
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        bit pause_here;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        long_hold_req = 1'b0;
        cur_mods      = '0;
        cur_keys      = '0;
        burst_left    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed reports. The comment on each says what it adds.
        // Same as the reset state: nothing changes.
        send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // Every modifier and six distinct keys go down at once.
        send_report(8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
        // Unchanged report.
        send_report(8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
        // Everything released.
        send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // One code in all slots: six separate presses of the same key.
        send_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // Half the modifiers up; the key is still held in fewer slots.
        send_report(8'hAA, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00);
        // Modifiers swap halves; repeated key released once per old slot.
        send_report(8'h55, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // Lowest modifier only, keys between empty slots.
        send_report(8'h01, 8'h04, 8'h00, 8'h05, 8'h00, 8'h06, 8'h00);
        // Highest modifier only; the same keys in other slots give no events.
        send_report(8'h80, 8'h06, 8'h05, 8'h04, 8'h00, 8'h00, 8'h00);
        // One key repeated, the others released.
        send_report(8'h80, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04);
        // Key codes that look like modifier codes, and the smallest code.
        send_report(8'h00, 8'hE0, 8'hE7, 8'h01, 8'h02, 8'h03, 8'hFE);
        // The largest report: 8 modifier presses, 6 key presses, 6 releases.
        send_report(8'hFF, 8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60);
        send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // Alternating bit patterns across all fields.
        send_report(8'h7F, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA);
        send_report(8'h80, 8'h7F, 8'h80, 8'hFE, 8'h01, 8'hAA, 8'h55);
        send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

        for (int i = 0; i < RANDOM_REPORTS; i++)
        begin
            // Early on the sink holds off for a long while so the block backs
            // up and pushes back on its input while reports keep coming.
            if (i == 40)
                long_hold_req = 1'b1;
            step_random_report();
            // Twice in the middle, and at the end, the sender stops until
            // every expected event has come out.
            pause_here = (i == 150 || i == 280 || i == RANDOM_REPORTS - 1);
            send_current(pause_here);
            if (pause_here)
                wait_events_drained();
        end

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
